### design/dmadcb_pkg.sv
// Package for the DMA descriptor chain builder: result kinds, transfer type
// and address step codes, controller states and the control/status structs.
// No dependencies.
`default_nettype none

package dmadcb_pkg;

  // Result kind codes.
  typedef enum logic [1:0] {
    KIND_CHAIN  = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // Transfer type codes.
  localparam logic [1:0] XFER_M2M = 2'd0;
  localparam logic [1:0] XFER_M2P = 2'd1;
  localparam logic [1:0] XFER_P2M = 2'd2;
  localparam logic [1:0] XFER_P2P = 2'd3;

  // Address step mode codes; the remaining two codes hold the address.
  localparam logic [1:0] STEP_INC = 2'd0;
  localparam logic [1:0] STEP_DEC = 2'd1;

  // Most descriptors one request may produce, plus one.
  localparam int unsigned CHAIN_MAX = 32;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SETUP = 2'd1,
    ST_EMIT  = 2'd2
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture a request word
    logic emit_single;  // give the single-block result
    logic emit_err;     // give the chain-too-long result
    logic emit_desc;    // give the next chained descriptor and step
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic single;       // request fits in one block
    logic err;          // chain would be too long
    logic last;         // current descriptor finishes the bytes
  } dp_status_t;

endpackage

`default_nettype wire

### design/dmadcb_ctrl.sv
// Controller state machine of the DMA descriptor chain builder.
// Depends on dmadcb_pkg for the state type and command/status structs.
`default_nettype none

module dmadcb_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire dmadcb_pkg::dp_status_t status_i,
  output dmadcb_pkg::dp_cmd_t         cmd_o
);

  dmadcb_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmadcb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      dmadcb_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = dmadcb_pkg::ST_SETUP;
        end
      end
      dmadcb_pkg::ST_SETUP: begin
        // The single-block check takes precedence over the length check.
        if (status_i.single) begin
          cmd_o.emit_single = 1'b1;
          state_d           = dmadcb_pkg::ST_IDLE;
        end else if (status_i.err) begin
          cmd_o.emit_err = 1'b1;
          state_d        = dmadcb_pkg::ST_IDLE;
        end else begin
          state_d = dmadcb_pkg::ST_EMIT;
        end
      end
      dmadcb_pkg::ST_EMIT: begin
        cmd_o.emit_desc = 1'b1;
        if (status_i.last) begin
          state_d = dmadcb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dmadcb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/dmadcb_dp.sv
// Datapath of the DMA descriptor chain builder: request registers, chunk
// sizing, length check, address stepping and the result registers.
// Depends on dmadcb_pkg for codes and the command/status structs.
`default_nettype none

module dmadcb_dp #(
  parameter int unsigned DESC_LIMIT      = 32,
  parameter int unsigned WORDS_PER_BLOCK = 31
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire dmadcb_pkg::dp_cmd_t    cmd_i,
  output dmadcb_pkg::dp_status_t      status_o,
  input  wire logic [31:0]            src_addr_i,
  input  wire logic [31:0]            dst_addr_i,
  input  wire logic [23:0]            total_bytes_i,
  input  wire logic [1:0]             transfer_type_i,
  input  wire logic [2:0]             src_burst_i,
  input  wire logic [2:0]             dst_burst_i,
  input  wire logic [1:0]             src_step_mode_i,
  input  wire logic [1:0]             dst_step_mode_i,
  input  wire logic [31:0]            ctrl_word_i,
  output logic                        out_valid_o,
  output logic [1:0]                  kind_o,
  output logic [4:0]                  desc_index_o,
  output logic [31:0]                 desc_src_o,
  output logic [31:0]                 desc_dst_o,
  output logic [31:0]                 desc_ctrl_o,
  output logic [4:0]                  block_count_o,
  output logic                        last_o
);

  // Effective chain limit: the parameter, capped at the result limit.
  localparam int unsigned LIM = (DESC_LIMIT < dmadcb_pkg::CHAIN_MAX) ?
                                DESC_LIMIT : dmadcb_pkg::CHAIN_MAX;
  localparam int unsigned LIM_M1    = LIM - 1;
  localparam logic [10:0] CHUNK_FIX = 11'(WORDS_PER_BLOCK * 4);
  localparam logic [23:0] THR_FIX   = 24'(LIM_M1 * WORDS_PER_BLOCK * 4);
  localparam logic [4:0]  BLK_FIX   = 5'(WORDS_PER_BLOCK);

  // Request registers; rem_q holds the bytes not yet covered.
  logic [31:0] src_q, dst_q, ctrl_q;
  logic [23:0] rem_q;
  logic [1:0]  type_q, smode_q, dmode_q;
  logic [2:0]  sburst_q, dburst_q;
  logic [4:0]  idx_q;

  // Result registers.
  logic        valid_q;
  logic [1:0]  kind_q;
  logic [4:0]  oidx_q, blk_q;
  logic [31:0] osrc_q, odst_q, octrl_q;
  logic        last_q;

  logic [22:0] words;
  logic        peri;
  logic [2:0]  burst_sel;
  logic [3:0]  shift;
  logic [10:0] chunk_bytes;
  logic [23:0] chunk_ext, thr;
  logic        fin, trim;
  logic [7:0]  trim_sum;
  logic [4:0]  blk;
  logic [31:0] src_step, dst_step;

  // Chunk size and the too-long threshold for the stored request.
  always_comb begin
    words     = 23'((25'(rem_q) + 25'd3) >> 2);
    peri      = (type_q == dmadcb_pkg::XFER_M2P) || (type_q == dmadcb_pkg::XFER_P2M);
    burst_sel = (type_q == dmadcb_pkg::XFER_M2P) ? dburst_q : sburst_q;
    shift     = (burst_sel == 3'd0) ? 4'd2 : (4'(burst_sel) + 4'd3);
    chunk_bytes = peri ? (11'd1 << shift) : CHUNK_FIX;
    chunk_ext = 24'(chunk_bytes);
    thr       = peri ? (24'(LIM_M1) << shift) : THR_FIX;
  end

  // Final chunk detection and trimming of a short memory-to-memory tail.
  always_comb begin
    fin      = rem_q <= chunk_ext;
    trim     = fin && (rem_q < chunk_ext) && (type_q == dmadcb_pkg::XFER_M2M);
    trim_sum = 8'(rem_q[6:0]) + 8'd3;
    if (trim) begin
      blk = trim_sum[6:2];
    end else if (peri) begin
      blk = 5'd1;
    end else begin
      blk = BLK_FIX;
    end
  end

  // Address stepping by one chunk.
  always_comb begin
    unique case (smode_q)
      dmadcb_pkg::STEP_INC: src_step = src_q + 32'(chunk_bytes);
      dmadcb_pkg::STEP_DEC: src_step = src_q - 32'(chunk_bytes);
      default:              src_step = src_q;
    endcase
    unique case (dmode_q)
      dmadcb_pkg::STEP_INC: dst_step = dst_q + 32'(chunk_bytes);
      dmadcb_pkg::STEP_DEC: dst_step = dst_q - 32'(chunk_bytes);
      default:              dst_step = dst_q;
    endcase
  end

  assign status_o.single = words <= 23'(WORDS_PER_BLOCK);
  assign status_o.err    = rem_q > thr;
  assign status_o.last   = fin;

  // Request word capture and per-descriptor update.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      src_q    <= src_addr_i;
      dst_q    <= dst_addr_i;
      ctrl_q   <= ctrl_word_i;
      rem_q    <= total_bytes_i;
      type_q   <= transfer_type_i;
      sburst_q <= src_burst_i;
      dburst_q <= dst_burst_i;
      smode_q  <= src_step_mode_i;
      dmode_q  <= dst_step_mode_i;
      idx_q    <= '0;
    end else if (cmd_i.emit_desc) begin
      src_q <= src_step;
      dst_q <= dst_step;
      rem_q <= fin ? '0 : (rem_q - chunk_ext);
      idx_q <= idx_q + 5'd1;
    end
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit_single || cmd_i.emit_err || cmd_i.emit_desc;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_single) begin
      kind_q  <= dmadcb_pkg::KIND_SINGLE;
      oidx_q  <= '0;
      osrc_q  <= src_q;
      odst_q  <= dst_q;
      octrl_q <= ctrl_q;
      blk_q   <= rem_q[6:2];
      last_q  <= 1'b1;
    end else if (cmd_i.emit_err) begin
      kind_q  <= dmadcb_pkg::KIND_ERROR;
      oidx_q  <= '0;
      osrc_q  <= '0;
      odst_q  <= '0;
      octrl_q <= '0;
      blk_q   <= '0;
      last_q  <= 1'b1;
    end else if (cmd_i.emit_desc) begin
      kind_q  <= dmadcb_pkg::KIND_CHAIN;
      oidx_q  <= idx_q;
      osrc_q  <= src_q;
      odst_q  <= dst_q;
      octrl_q <= ctrl_q;
      blk_q   <= blk;
      last_q  <= fin;
    end
  end

  assign out_valid_o   = valid_q;
  assign kind_o        = kind_q;
  assign desc_index_o  = oidx_q;
  assign desc_src_o    = osrc_q;
  assign desc_dst_o    = odst_q;
  assign desc_ctrl_o   = octrl_q;
  assign block_count_o = blk_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

### design/dma_descriptor_chain_builder.sv
// Top level of the DMA descriptor chain builder: controller plus datapath.
// Depends on dmadcb_pkg, dmadcb_ctrl and dmadcb_dp.
//
//   Channel   Handshake                 Payload
//   request   start in, busy out        src_addr_i .. ctrl_word_i
//   result    out_valid_o (one cycle)   kind_o .. last_o
//
// A request word is taken when start is high and busy is low. The
// request is then classified in the setup state; a single-block or error
// result appears on the next cycle. A chain of N descriptors gives one
// word per cycle after the classify cycle. Busy stays high until the
// controller is idle again, so a new request waits until this one is done.
// Reset returns the controller to idle and clears the result strobe. The
// receiver cannot stall; each result word is valid for exactly one cycle.
`default_nettype none

module dma_descriptor_chain_builder #(
  parameter int unsigned DESC_LIMIT      = 32,
  parameter int unsigned WORDS_PER_BLOCK = 31
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] src_addr_i,
  input  wire logic [31:0] dst_addr_i,
  input  wire logic [23:0] total_bytes_i,
  input  wire logic [1:0]  transfer_type_i,
  input  wire logic [2:0]  src_burst_i,
  input  wire logic [2:0]  dst_burst_i,
  input  wire logic [1:0]  src_step_mode_i,
  input  wire logic [1:0]  dst_step_mode_i,
  input  wire logic [31:0] ctrl_word_i,
  output logic             out_valid_o,
  output logic [1:0]       kind_o,
  output logic [4:0]       desc_index_o,
  output logic [31:0]      desc_src_o,
  output logic [31:0]      desc_dst_o,
  output logic [31:0]      desc_ctrl_o,
  output logic [4:0]       block_count_o,
  output logic             last_o
);

  dmadcb_pkg::dp_cmd_t    cmd;
  dmadcb_pkg::dp_status_t status;

  // Sequencing of each request.
  dmadcb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Chunking, stepping and result registers.
  dmadcb_dp #(
    .DESC_LIMIT      (DESC_LIMIT),
    .WORDS_PER_BLOCK (WORDS_PER_BLOCK)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .src_addr_i      (src_addr_i),
    .dst_addr_i      (dst_addr_i),
    .total_bytes_i   (total_bytes_i),
    .transfer_type_i (transfer_type_i),
    .src_burst_i     (src_burst_i),
    .dst_burst_i     (dst_burst_i),
    .src_step_mode_i (src_step_mode_i),
    .dst_step_mode_i (dst_step_mode_i),
    .ctrl_word_i     (ctrl_word_i),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .desc_index_o    (desc_index_o),
    .desc_src_o      (desc_src_o),
    .desc_dst_o      (desc_dst_o),
    .desc_ctrl_o     (desc_ctrl_o),
    .block_count_o   (block_count_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire
